// ===== rtl/core/hybrid_pca_segmenter_assert.svh =====
// Assertion macros used by the segmenter top level.
`ifndef HYBRID_PCA_SEGMENTER_ASSERT_SVH
`define HYBRID_PCA_SEGMENTER_ASSERT_SVH

// Check that cons holds in the same cycle as ante.
`define HPS_ASSERT_NOW(name, clk, rst, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Check that cons holds in the cycle after ante.
`define HPS_ASSERT_NEXT(name, clk, rst, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/hps_pkg.sv =====
// Shared types and constants of the segmenter.
`default_nettype none

package hps_pkg;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;
  localparam int EB_W       = 16;
  localparam int WL_W       = 5;
  localparam int WPS_W      = 8;
  localparam int LEN_W      = 12;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ERROR_BOUND = 2'd0,
    REG_WINDOW_LEN  = 2'd1,
    REG_WPS         = 2'd2
  } cfg_reg_t;

  // Source of an emitted segment
  typedef enum logic [1:0] {
    EMIT_BUF  = 2'd0,
    EMIT_JOIN = 2'd1,
    EMIT_WIN  = 2'd2,
    EMIT_PMC  = 2'd3
  } emit_sel_t;

  typedef struct packed {
    logic      push;
    logic      merge;
    logic      buf_load_win;
    logic      clr_buf;
    logic      clr_win;
    logic      pmc_init;
    logic      pmc_adv;
    logic      emit;
    emit_sel_t emit_sel;
    logic      emit_last;
  } cmd_t;

  typedef struct packed {
    logic op_finish;
    logic full;
    logic joinable;
    logic wfits;
    logic buf_nonempty;
    logic win_nonempty;
    logic wps_reached;
    logic pmc_cut;
    logic pmc_last;
    logic out_free;
  } status_t;

endpackage

`default_nettype wire

// ===== rtl/core/hps_if.sv =====
// Valid/ready channel interfaces for samples in and segments out.
`default_nettype none

interface hps_in_if #(
  parameter int SAMPLE_BITS = 16
) ();
  logic                          valid;
  logic                          ready;
  logic                          opcode;
  logic signed [SAMPLE_BITS-1:0] sample;

  modport source (output valid, output opcode, output sample, input ready);
  modport sink (input valid, input opcode, input sample, output ready);
endinterface

interface hps_out_if #(
  parameter int SAMPLE_BITS = 16
) ();
  logic                        valid;
  logic                        ready;
  logic [11:0]                 seg_length;
  logic signed [SAMPLE_BITS:0] seg_value_x2;
  logic                        run_last;

  modport source (output valid, output seg_length, output seg_value_x2, output run_last,
                  input ready);
  modport sink (input valid, input seg_length, input seg_value_x2, input run_last,
                output ready);
endinterface

`default_nettype wire

// ===== rtl/core/hps_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module hps_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ===== rtl/core/hps_ctrl.sv =====
// Controller state machine: sequences window checks, flushes, finishes and re-splits.
`default_nettype none

module hps_ctrl (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             in_valid,
  output logic                  in_ready,
  input  wire hps_pkg::status_t st,
  output hps_pkg::cmd_t         cmd
);
  import hps_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EVAL,
    S_WPS,
    S_FLUSH,
    S_FIN,
    S_FINWIN,
    S_PMC,
    S_PMCEND
  } state_t;

  state_t state, state_next;
  logic   fin_mode, fin_mode_next;

  assign in_ready = (state == S_IDLE);

  // Next state and datapath commands
  always_comb begin
    state_next    = state;
    fin_mode_next = fin_mode;
    cmd           = '0;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          fin_mode_next = st.op_finish;
          if (st.op_finish) begin
            state_next = S_FIN;
          end else begin
            cmd.push   = 1'b1;
            state_next = S_EVAL;
          end
        end
      end
      S_EVAL: begin
        if (!st.full) begin
          state_next = S_IDLE;
        end else if (st.joinable) begin
          cmd.merge  = 1'b1;
          state_next = S_WPS;
        end else begin
          state_next = S_FLUSH;
        end
      end
      S_WPS: begin
        if (!st.wps_reached) begin
          cmd.clr_win = 1'b1;
          state_next  = S_IDLE;
        end else if (st.out_free) begin
          cmd.emit      = 1'b1;
          cmd.emit_sel  = EMIT_BUF;
          cmd.emit_last = 1'b1;
          cmd.clr_buf   = 1'b1;
          cmd.clr_win   = 1'b1;
          state_next    = S_IDLE;
        end
      end
      S_FLUSH: begin
        if (!st.buf_nonempty || st.out_free) begin
          // Emit the held buffer first, then deal with the window
          if (st.buf_nonempty) begin
            cmd.emit      = 1'b1;
            cmd.emit_sel  = EMIT_BUF;
            cmd.emit_last = st.wfits && (!fin_mode || !st.win_nonempty);
          end
          cmd.clr_buf = 1'b1;
          if (!st.wfits) begin
            cmd.pmc_init = 1'b1;
            state_next   = S_PMC;
          end else if (!fin_mode) begin
            cmd.buf_load_win = 1'b1;
            cmd.clr_win      = 1'b1;
            state_next       = S_IDLE;
          end else if (st.win_nonempty) begin
            state_next = S_FINWIN;
          end else begin
            cmd.clr_win = 1'b1;
            state_next  = S_IDLE;
          end
        end
      end
      S_FIN: begin
        if (!st.win_nonempty && !st.buf_nonempty) begin
          cmd.clr_buf = 1'b1;
          cmd.clr_win = 1'b1;
          state_next  = S_IDLE;
        end else if (st.joinable) begin
          if (st.out_free) begin
            cmd.emit      = 1'b1;
            cmd.emit_sel  = EMIT_JOIN;
            cmd.emit_last = 1'b1;
            cmd.clr_buf   = 1'b1;
            cmd.clr_win   = 1'b1;
            state_next    = S_IDLE;
          end
        end else begin
          state_next = S_FLUSH;
        end
      end
      S_FINWIN: begin
        if (st.out_free) begin
          cmd.emit      = 1'b1;
          cmd.emit_sel  = EMIT_WIN;
          cmd.emit_last = 1'b1;
          cmd.clr_buf   = 1'b1;
          cmd.clr_win   = 1'b1;
          state_next    = S_IDLE;
        end
      end
      S_PMC: begin
        // Hold on a cut while the output beat is still waiting
        if (!st.pmc_cut || st.out_free) begin
          cmd.pmc_adv = 1'b1;
          if (st.pmc_cut) begin
            cmd.emit     = 1'b1;
            cmd.emit_sel = EMIT_PMC;
          end
          if (st.pmc_last) begin
            state_next = S_PMCEND;
          end
        end
      end
      S_PMCEND: begin
        if (st.out_free) begin
          cmd.emit      = 1'b1;
          cmd.emit_sel  = EMIT_PMC;
          cmd.emit_last = 1'b1;
          cmd.clr_buf   = 1'b1;
          cmd.clr_win   = 1'b1;
          state_next    = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // State and mode registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      fin_mode <= 1'b0;
    end else begin
      state    <= state_next;
      fin_mode <= fin_mode_next;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/hps_datapath.sv =====
// Datapath: configuration, window and buffer ranges, re-split walk, output register.
`default_nettype none

module hps_datapath #(
  parameter int MAX_WINDOW_LEN = 16,
  parameter int SAMPLE_BITS    = 16
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  input  wire logic                                 cfg_we,
  input  wire logic [hps_pkg::CFG_IDX_W-1:0]        cfg_addr,
  input  wire logic [hps_pkg::CFG_DATA_W-1:0]       cfg_data,
  input  wire logic                                 opcode,
  input  wire logic signed [SAMPLE_BITS-1:0]        sample,
  input  wire hps_pkg::cmd_t                        cmd,
  output hps_pkg::status_t                          st,
  hps_out_if.source                                 seg_ch
);
  import hps_pkg::*;

  localparam int CNT_W  = $clog2(MAX_WINDOW_LEN + 1);
  localparam int IDX_W  = $clog2(MAX_WINDOW_LEN);
  localparam int VX_W   = SAMPLE_BITS + 1;
  localparam int FIT_W  = (SAMPLE_BITS + 2 > EB_W + 2) ? SAMPLE_BITS + 2 : EB_W + 2;
  localparam int PROD_W = WPS_W + CNT_W + LEN_W;
  localparam logic signed [SAMPLE_BITS-1:0] SMAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
  localparam logic signed [SAMPLE_BITS-1:0] SMIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

  function automatic logic fits(input logic signed [SAMPLE_BITS-1:0] lo,
                                input logic signed [SAMPLE_BITS-1:0] hi,
                                input logic [EB_W-1:0] eb);
    logic signed [FIT_W-1:0] diff;
    logic signed [FIT_W-1:0] bound;
    diff  = FIT_W'(hi) - FIT_W'(lo);
    bound = $signed(FIT_W'({eb, 1'b0}));
    return diff <= bound;
  endfunction

  logic [EB_W-1:0]  error_bound;
  logic [WL_W-1:0]  window_len;
  logic [WPS_W-1:0] windows_per_segment;

  logic [CNT_W-1:0]              window_count;
  logic signed [SAMPLE_BITS-1:0] window_min, window_max;
  logic [WPS_W-1:0]              buffer_count;
  logic signed [SAMPLE_BITS-1:0] buffer_min, buffer_max;

  logic [IDX_W-1:0]              idx;
  logic signed [SAMPLE_BITS-1:0] p_lo, p_hi;
  logic signed [VX_W-1:0]        p_vx2;
  logic [CNT_W-1:0]              p_len;

  logic [CNT_W-1:0]              eff_len;
  logic [WPS_W-1:0]              wps_eff;
  logic signed [SAMPLE_BITS-1:0] j_lo, j_hi;
  logic signed [SAMPLE_BITS-1:0] y, lo_n, hi_n;
  logic [SAMPLE_BITS-1:0]        rd_data;
  logic [IDX_W-1:0]              raddr;
  logic                          cut;
  logic [PROD_W-1:0]             buf_prod;
  logic [LEN_W-1:0]              emit_len;
  logic signed [VX_W-1:0]        emit_vx2;

  // Configuration writes; unknown indexes are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      error_bound         <= '0;
      window_len          <= WL_W'(16);
      windows_per_segment <= WPS_W'(4);
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_addr))
        REG_ERROR_BOUND: error_bound         <= cfg_data[EB_W-1:0];
        REG_WINDOW_LEN:  window_len          <= cfg_data[WL_W-1:0];
        REG_WPS:         windows_per_segment <= cfg_data[WPS_W-1:0];
        default: ;
      endcase
    end
  end

  // Effective window length and windows per segment
  always_comb begin
    if (window_len == '0) begin
      eff_len = CNT_W'(1);
    end else if (int'(window_len) > MAX_WINDOW_LEN) begin
      eff_len = CNT_W'(MAX_WINDOW_LEN);
    end else begin
      eff_len = CNT_W'(window_len);
    end
    wps_eff = (windows_per_segment == '0) ? WPS_W'(1) : windows_per_segment;
  end

  // Merged range of buffer and window
  assign j_lo = (buffer_min < window_min) ? buffer_min : window_min;
  assign j_hi = (buffer_max > window_max) ? buffer_max : window_max;

  // Window store
  assign raddr = cmd.pmc_init ? '0 : (cmd.pmc_adv ? IDX_W'(idx + IDX_W'(1)) : idx);

  hps_ram #(
    .WIDTH (SAMPLE_BITS),
    .DEPTH (MAX_WINDOW_LEN)
  ) u_store (
    .clk   (clk),
    .we    (cmd.push),
    .waddr (window_count[IDX_W-1:0]),
    .wdata (sample),
    .raddr (raddr),
    .rdata (rd_data)
  );

  // Current window count and range
  always_ff @(posedge clk) begin
    if (rst || cmd.clr_win) begin
      window_count <= '0;
      window_min   <= SMAX;
      window_max   <= SMIN;
    end else if (cmd.push) begin
      window_count <= window_count + CNT_W'(1);
      if (sample < window_min) begin
        window_min <= sample;
      end
      if (sample > window_max) begin
        window_max <= sample;
      end
    end
  end

  // Window buffer count and range
  always_ff @(posedge clk) begin
    if (rst) begin
      buffer_count <= '0;
      buffer_min   <= SMAX;
      buffer_max   <= SMIN;
    end else if (cmd.buf_load_win) begin
      buffer_count <= WPS_W'(1);
      buffer_min   <= window_min;
      buffer_max   <= window_max;
    end else if (cmd.clr_buf) begin
      buffer_count <= '0;
      buffer_min   <= SMAX;
      buffer_max   <= SMIN;
    end else if (cmd.merge) begin
      buffer_count <= buffer_count + WPS_W'(1);
      buffer_min   <= j_lo;
      buffer_max   <= j_hi;
    end
  end

  // Re-split walk over the stored points
  assign y    = $signed(rd_data);
  assign lo_n = (y < p_lo) ? y : p_lo;
  assign hi_n = (y > p_hi) ? y : p_hi;
  assign cut  = !fits(lo_n, hi_n, error_bound);

  always_ff @(posedge clk) begin
    if (cmd.pmc_init) begin
      idx   <= '0;
      p_lo  <= SMAX;
      p_hi  <= SMIN;
      p_len <= '0;
      p_vx2 <= '0;
    end else if (cmd.pmc_adv) begin
      idx <= IDX_W'(idx + IDX_W'(1));
      if (cut) begin
        p_lo  <= y;
        p_hi  <= y;
        p_len <= CNT_W'(1);
        p_vx2 <= VX_W'(y) + VX_W'(y);
      end else begin
        p_lo  <= lo_n;
        p_hi  <= hi_n;
        p_len <= p_len + CNT_W'(1);
        p_vx2 <= VX_W'(lo_n) + VX_W'(hi_n);
      end
    end
  end

  // Segment length and value for the selected source
  assign buf_prod = PROD_W'(buffer_count) * PROD_W'(eff_len);

  always_comb begin
    case (cmd.emit_sel)
      EMIT_BUF: begin
        emit_len = LEN_W'(buf_prod);
        emit_vx2 = VX_W'(buffer_min) + VX_W'(buffer_max);
      end
      EMIT_JOIN: begin
        emit_len = LEN_W'(buf_prod + PROD_W'(window_count));
        emit_vx2 = VX_W'(j_lo) + VX_W'(j_hi);
      end
      EMIT_WIN: begin
        emit_len = LEN_W'(window_count);
        emit_vx2 = VX_W'(window_min) + VX_W'(window_max);
      end
      EMIT_PMC: begin
        emit_len = LEN_W'(p_len);
        emit_vx2 = p_vx2;
      end
      default: begin
        emit_len = '0;
        emit_vx2 = '0;
      end
    endcase
  end

  // Output register: valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      seg_ch.valid <= 1'b0;
    end else if (cmd.emit) begin
      seg_ch.valid <= 1'b1;
    end else if (seg_ch.ready) begin
      seg_ch.valid <= 1'b0;
    end
  end

  // Output register: payload
  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      seg_ch.seg_length   <= emit_len;
      seg_ch.seg_value_x2 <= emit_vx2;
      seg_ch.run_last     <= cmd.emit_last;
    end
  end

  // Status to the controller
  always_comb begin
    st.op_finish    = opcode;
    st.full         = (window_count >= eff_len);
    st.joinable     = fits(j_lo, j_hi, error_bound);
    st.wfits        = fits(window_min, window_max, error_bound);
    st.buf_nonempty = (buffer_count != '0);
    st.win_nonempty = (window_count != '0);
    st.wps_reached  = (buffer_count >= wps_eff);
    st.pmc_cut      = cut;
    st.pmc_last     = ((CNT_W'(idx) + CNT_W'(1)) == window_count);
    st.out_free     = !seg_ch.valid || seg_ch.ready;
  end

endmodule

`default_nettype wire

// ===== rtl/core/hybrid_pca_segmenter.sv =====
// Hybrid piecewise constant segmenter: samples in, constant segments out.
// A sample that does not complete a window is accepted, then the window is
// checked. Completing a window merges it into the buffer and tests the buffer,
// or flushes the buffer; a window whose own range is too wide is re-split by
// walking the window store through its registered read port, which the flush
// state primes; the walk visits each stored point, then emits the final segment.
// A finish passes the finish state and, as needed, a flush and a window emit,
// or the re-split walk. Each segment waits for the single output register to
// be free, so a slow consumer stalls these steps. The window store is not
// cleared after reset: only points written in the current window are ever read.
`default_nettype none

module hybrid_pca_segmenter #(
  parameter int MAX_WINDOW_LEN = 16,
  parameter int SAMPLE_BITS    = 16
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            cfg_we,
  input  wire logic [hps_pkg::CFG_IDX_W-1:0]   cfg_addr,
  input  wire logic [hps_pkg::CFG_DATA_W-1:0]  cfg_data,
  hps_in_if.sink                               sample_ch,
  hps_out_if.source                            seg_ch
);
  import hps_pkg::*;

  `include "hybrid_pca_segmenter_assert.svh"

  cmd_t    cmd;
  status_t st;
  logic    in_ready;

  assign sample_ch.ready = in_ready;

  hps_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (sample_ch.valid),
    .in_ready (in_ready),
    .st       (st),
    .cmd      (cmd)
  );

  hps_datapath #(
    .MAX_WINDOW_LEN (MAX_WINDOW_LEN),
    .SAMPLE_BITS    (SAMPLE_BITS)
  ) u_datapath (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_addr (cfg_addr),
    .cfg_data (cfg_data),
    .opcode   (sample_ch.opcode),
    .sample   (sample_ch.sample),
    .cmd      (cmd),
    .st       (st),
    .seg_ch   (seg_ch)
  );

  // A segment is only loaded when the output register can take it
  `HPS_ASSERT_NOW(a_emit_free, clk, rst, cmd.emit, st.out_free, "emit into a held beat")
  // One item at a time: after an accepted beat the input is closed
  `HPS_ASSERT_NEXT(a_accept_close, clk, rst, sample_ch.valid && sample_ch.ready, !sample_ch.ready, "input open after accept")
  // The last segment of an item returns the block to idle
  `HPS_ASSERT_NEXT(a_last_idle, clk, rst, cmd.emit && cmd.emit_last, sample_ch.ready, "not idle after last segment")

endmodule

`default_nettype wire
